// ===== rtl/onenc_pkg.sv =====
package onenc_pkg;

	// Fixed widths of the interface fields.
	localparam int COMP_W = 16;
	localparam int CODE_W = 16;
	localparam int WORD_W = 32;

	// |x|+|y|+|z| stays below 2^17, and n+s, which runs from 0 to 2s, stays below 2^18.
	localparam int SUM_W  = COMP_W + 1;
	localparam int TERM_W = COMP_W + 2;
	// The divisor is 2s, and the partial remainder always stays below it.
	localparam int DIV_W  = TERM_W;

	typedef struct packed {
		logic signed [COMP_W-1:0] dir_x;
		logic signed [COMP_W-1:0] dir_y;
		logic signed [COMP_W-1:0] dir_z;
	} dir_req_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_u;
		logic [CODE_W-1:0] code_v;
		logic [WORD_W-1:0] packed_word;
		logic              zero_input;
	} code_req_t;

	// The fixed-width part of the data that travels down the divider chain.
	typedef struct packed {
		logic [DIV_W-1:0] rem_u;
		logic [DIV_W-1:0] rem_v;
		logic [DIV_W-1:0] divisor;
		logic             zero;
	} div_fix_t;

endpackage

// ===== rtl/onenc_front.sv =====
module onenc_front #(
	parameter int CODE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_take,
	input  onenc_pkg::dir_req_t dir,
	output logic                out_valid,
	input  logic                out_take,
	output onenc_pkg::div_fix_t out_fix,
	output logic [CODE_BITS-1:0] out_sh_u,
	output logic [CODE_BITS-1:0] out_sh_v
);
	import onenc_pkg::*;

	localparam int NUM_W = CODE_BITS + TERM_W;

	logic [COMP_W-1:0] ax, ay, az;
	logic [SUM_W-1:0]  s_sum;
	logic [TERM_W-1:0] t_up_u, t_up_v, t_u, t_v;

	logic              valid_s1;
	logic [SUM_W-1:0]  s_s1;
	logic [TERM_W-1:0] tu_s1, tv_s1;
	logic              zero_s1;
	logic              en_s1;

	logic              valid_s2;
	logic              en_s2;
	logic [NUM_W-1:0]  num_u, num_v;

	// Stage one: magnitudes, the L1 norm and the shifted numerators n+s.
	always_comb begin
		ax = dir.dir_x[COMP_W-1] ? (~dir.dir_x + COMP_W'(1)) : dir.dir_x;
		ay = dir.dir_y[COMP_W-1] ? (~dir.dir_y + COMP_W'(1)) : dir.dir_y;
		az = dir.dir_z[COMP_W-1] ? (~dir.dir_z + COMP_W'(1)) : dir.dir_z;
		s_sum = SUM_W'(ax) + SUM_W'(ay) + SUM_W'(az);
		t_up_u = {{(TERM_W-COMP_W){dir.dir_x[COMP_W-1]}}, dir.dir_x} + TERM_W'(s_sum);
		t_up_v = {{(TERM_W-COMP_W){dir.dir_z[COMP_W-1]}}, dir.dir_z} + TERM_W'(s_sum);
		if (!dir.dir_y[COMP_W-1]) begin
			t_u = t_up_u;
			t_v = t_up_v;
		end else begin
			// In the folded hemisphere n+s is either 2s-|other| or |other|.
			t_u = dir.dir_x[COMP_W-1] ? TERM_W'(az) : ({s_sum, 1'b0} - TERM_W'(az));
			t_v = dir.dir_z[COMP_W-1] ? TERM_W'(ax) : ({s_sum, 1'b0} - TERM_W'(ax));
		end
	end

	assign en_s1   = !valid_s1 || en_s2;
	assign en_s2   = !valid_s2 || out_take;
	assign in_take = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			s_s1    <= s_sum;
			tu_s1   <= t_u;
			tv_s1   <= t_v;
			zero_s1 <= (s_sum == '0);
		end
	end

	// Stage two: the dividend M*(n+s)+s, where M*t is (t << CODE_BITS) - t.
	always_comb begin
		num_u = {tu_s1, {CODE_BITS{1'b0}}} - NUM_W'(tu_s1) + NUM_W'(s_s1);
		num_v = {tv_s1, {CODE_BITS{1'b0}}} - NUM_W'(tv_s1) + NUM_W'(s_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			out_fix.rem_u   <= num_u[NUM_W-1:CODE_BITS];
			out_fix.rem_v   <= num_v[NUM_W-1:CODE_BITS];
			out_fix.divisor <= {s_s1, 1'b0};
			out_fix.zero    <= zero_s1;
			out_sh_u        <= num_u[CODE_BITS-1:0];
			out_sh_v        <= num_v[CODE_BITS-1:0];
		end
	end

	assign out_valid = valid_s2;

endmodule

// ===== rtl/onenc_div_cell.sv =====
module onenc_div_cell #(
	parameter int CODE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_take,
	input  onenc_pkg::div_fix_t  in_fix,
	input  logic [CODE_BITS-1:0] in_sh_u,
	input  logic [CODE_BITS-1:0] in_sh_v,
	output logic                 out_valid,
	input  logic                 out_take,
	output onenc_pkg::div_fix_t  out_fix,
	output logic [CODE_BITS-1:0] out_sh_u,
	output logic [CODE_BITS-1:0] out_sh_v
);
	import onenc_pkg::*;

	// One restoring division step per lane. The shift word feeds dividend bits
	// in at the top and collects quotient bits at the bottom.
	logic [DIV_W:0]   trial_u, trial_v, dvs;
	logic             ge_u, ge_v;
	logic [DIV_W:0]   diff_u, diff_v;
	logic             valid_q;
	div_fix_t         fix_q;
	logic [CODE_BITS-1:0] sh_u_q, sh_v_q;

	always_comb begin
		dvs     = {1'b0, in_fix.divisor};
		trial_u = {in_fix.rem_u, in_sh_u[CODE_BITS-1]};
		trial_v = {in_fix.rem_v, in_sh_v[CODE_BITS-1]};
		ge_u    = (trial_u >= dvs);
		ge_v    = (trial_v >= dvs);
		diff_u  = ge_u ? (trial_u - dvs) : trial_u;
		diff_v  = ge_v ? (trial_v - dvs) : trial_v;
	end

	assign in_take = !valid_q || out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_take) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && in_valid) begin
			fix_q.rem_u   <= diff_u[DIV_W-1:0];
			fix_q.rem_v   <= diff_v[DIV_W-1:0];
			fix_q.divisor <= in_fix.divisor;
			fix_q.zero    <= in_fix.zero;
			sh_u_q        <= {in_sh_u[CODE_BITS-2:0], ge_u};
			sh_v_q        <= {in_sh_v[CODE_BITS-2:0], ge_v};
		end
	end

	assign out_valid = valid_q;
	assign out_fix   = fix_q;
	assign out_sh_u  = sh_u_q;
	assign out_sh_v  = sh_v_q;

endmodule

// ===== rtl/octahedral_normal_encode_core.sv =====
// Octahedral normal encoder with y as the pole axis. Each request on the dir
// side carries one direction as three signed Q1.15 components and yields one
// request on the code side with the two CODE_BITS-bit codes, the packed word
// (u low, v high) and a flag for the all-zero vector, whose codes are zero.
// The block takes one request every cycle while the output is not stalled.
// Two front stages form the L1 norm and the dividends, then a chain of
// CODE_BITS restoring division cells, one per quotient bit, produces both
// codes side by side. The last cell doubles as the output register. Each
// stage holds its own valid bit, so a stalled output request freezes only
// the stages behind it that are full, and bubbles further up keep taking
// requests.
module octahedral_normal_encode_core #(
	parameter int CODE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 dir_valid,
	output logic                 dir_stall,
	input  onenc_pkg::dir_req_t  dir,
	output logic                 code_valid,
	input  logic                 code_stall,
	output onenc_pkg::code_req_t code
);
	import onenc_pkg::*;

	// Chain taps: index 0 is the front output, index CODE_BITS the last cell.
	logic                 valid_c [0:CODE_BITS];
	logic                 take_c  [0:CODE_BITS];
	div_fix_t             fix_c   [0:CODE_BITS];
	logic [CODE_BITS-1:0] sh_u_c  [0:CODE_BITS];
	logic [CODE_BITS-1:0] sh_v_c  [0:CODE_BITS];
	logic                 front_take;
	logic [CODE_W-1:0]    code_u_w, code_v_w;

	onenc_front #(
		.CODE_BITS(CODE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dir_valid),
		.in_take  (front_take),
		.dir      (dir),
		.out_valid(valid_c[0]),
		.out_take (take_c[0]),
		.out_fix  (fix_c[0]),
		.out_sh_u (sh_u_c[0]),
		.out_sh_v (sh_v_c[0])
	);

	for (genvar i = 0; i < CODE_BITS; i++) begin : g_cell
		onenc_div_cell #(
			.CODE_BITS(CODE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_c[i]),
			.in_take  (take_c[i]),
			.in_fix   (fix_c[i]),
			.in_sh_u  (sh_u_c[i]),
			.in_sh_v  (sh_v_c[i]),
			.out_valid(valid_c[i+1]),
			.out_take (take_c[i+1]),
			.out_fix  (fix_c[i+1]),
			.out_sh_u (sh_u_c[i+1]),
			.out_sh_v (sh_v_c[i+1])
		);
	end

	assign take_c[CODE_BITS] = !code_stall;
	assign dir_stall         = !front_take;

	// After the last cell the shift words hold the quotients. The quotient
	// never exceeds 2^CODE_BITS - 1, so no clamp is needed. A zero vector
	// divides by zero inside the chain, and its garbage is masked here.
	always_comb begin
		code_u_w = fix_c[CODE_BITS].zero ? '0 : CODE_W'(sh_u_c[CODE_BITS]);
		code_v_w = fix_c[CODE_BITS].zero ? '0 : CODE_W'(sh_v_c[CODE_BITS]);
		code.code_u      = code_u_w;
		code.code_v      = code_v_w;
		code.packed_word = {code_v_w, code_u_w};
		code.zero_input  = fix_c[CODE_BITS].zero;
	end

	assign code_valid = valid_c[CODE_BITS];

`ifndef NO_ASSERTIONS
	// A zero vector always leaves with an all-zero packed word.
	a_zero_codes: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code.zero_input |-> code.packed_word == '0)
		else $error("zero vector produced nonzero codes");

	// The packed word carries exactly the two codes.
	a_packing: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> code.packed_word == {code.code_v, code.code_u})
		else $error("packed word does not match codes");

	// Codes never use bits above CODE_BITS.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> ((code.code_u >> CODE_BITS) == '0) &&
			((code.code_v >> CODE_BITS) == '0))
		else $error("code exceeds CODE_BITS");

	// Requests are held back only when the chain is full and the output stalls.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		dir_stall |-> code_valid && code_stall)
		else $error("request stalled while the chain could advance");
`endif

endmodule
